// ===== rtl/core/ftwm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ftwm_pkg;

    localparam int unsigned CNT_W     = 9;
    localparam int unsigned SUM_W     = 41;
    localparam int unsigned DIV_CNT_W = 6;
    localparam int unsigned CFG_W     = 32;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_START  = 2'd1,
        OP_STOP   = 2'd2,
        OP_CLEAR  = 2'd3
    } opcode_t;

    typedef enum logic [2:0] {
        ST_STARTED        = 3'd0,
        ST_ALREADY_ACTIVE = 3'd1,
        ST_RECORDED       = 3'd2,
        ST_NOT_ACTIVE     = 3'd3,
        ST_INVALID        = 3'd4,
        ST_STOPPED        = 3'd5,
        ST_CLEARED        = 3'd6
    } status_t;

    localparam logic REG_WINDOW_FRAMES   = 1'b0;
    localparam logic REG_SPIKE_THRESHOLD = 1'b1;

    localparam logic [8:0]  WINDOW_FRAMES_RST   = 9'd256;
    localparam logic [31:0] SPIKE_THRESHOLD_RST = 32'd16667;
    localparam logic [2:0]  NO_SOURCE           = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] frame_number;
        logic [47:0] stamp_us;
        logic [31:0] frame_time;
        logic [47:0] memory_used;
        logic [4:0]  present_mask;
        logic [31:0] render_time;
        logic [31:0] script_time;
        logic [31:0] asset_time;
        logic [31:0] audio_time;
        logic [31:0] misc_time;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic        active;
        logic [8:0]  frames_held;
        logic [31:0] latest_time;
        logic [47:0] latest_memory;
        logic [31:0] average_time;
        logic [31:0] maximum_time;
        logic        spike_valid;
        logic [31:0] spike_frame;
        logic [31:0] spike_time;
        logic [2:0]  dominant_source;
        logic [31:0] dominant_us;
    } out_item_t;

    typedef struct packed {
        logic load;
        logic decide;
        logic drop;
        logic write;
        logic check;
        logic walk;
        logic div_start;
        logic div_step;
        logic publish;
    } dp_cmd_t;

    typedef struct packed {
        logic record_ok;
        logic drop_needed;
        logic walk_done;
        logic div_done;
    } dp_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/ftwm_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface ftwm_in_if;
    import ftwm_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

interface ftwm_out_if;
    import ftwm_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink (input valid, input item, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/ftwm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftwm_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    input  ftwm_pkg::dp_stat_t stat,
    output ftwm_pkg::dp_cmd_t  cmd
);
    import ftwm_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECIDE,
        S_DROP_RD,
        S_DROP_SUB,
        S_WRITE,
        S_CHECK_RD,
        S_CHECK,
        S_WALK,
        S_DIVIDE,
        S_RESULT
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   publish_ok;

    assign in_ready   = (state_reg == S_IDLE);
    assign out_valid  = out_valid_reg;
    assign publish_ok = !out_valid_reg || out_ready;

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:     cmd.load = in_valid;
            S_DECIDE:   cmd.decide = 1'b1;
            S_DROP_RD:  cmd = '0;
            S_DROP_SUB: cmd.drop = 1'b1;
            S_WRITE:    cmd.write = 1'b1;
            S_CHECK_RD: cmd = '0;
            S_CHECK:    cmd.check = 1'b1;
            S_WALK:
            begin
                cmd.walk      = 1'b1;
                cmd.div_start = stat.walk_done;
            end
            S_DIVIDE:   cmd.div_step = !stat.div_done;
            S_RESULT:   cmd.publish = publish_ok;
            default:    cmd = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == S_RESULT) && publish_ok)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:   state_reg <= stat.record_ok ? S_DROP_RD : S_WALK;
                S_DROP_RD:  state_reg <= stat.drop_needed ? S_DROP_SUB : S_WRITE;
                S_DROP_SUB: state_reg <= S_DROP_RD;
                S_WRITE:    state_reg <= S_CHECK_RD;
                S_CHECK_RD: state_reg <= S_CHECK;
                S_CHECK:    state_reg <= S_WALK;
                S_WALK:
                begin
                    if (stat.walk_done)
                    begin
                        state_reg <= S_DIVIDE;
                    end
                end
                S_DIVIDE:
                begin
                    if (stat.div_done)
                    begin
                        state_reg <= S_RESULT;
                    end
                end
                S_RESULT:
                begin
                    if (publish_ok)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/ftwm_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftwm_datapath #(
    parameter int unsigned WINDOW_DEPTH = 256
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_we,
    input  logic                             cfg_index,
    input  logic [ftwm_pkg::CFG_W-1:0]       cfg_data,
    input  ftwm_pkg::in_item_t               in_item,
    input  ftwm_pkg::dp_cmd_t                cmd,
    output ftwm_pkg::dp_stat_t               stat,
    output ftwm_pkg::out_item_t              out_item
);
    import ftwm_pkg::*;

    localparam int unsigned AW  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int unsigned SW  = ((AW > CNT_W) ? AW : CNT_W) + 1;
    localparam int unsigned CAP = (WINDOW_DEPTH < 511) ? WINDOW_DEPTH : 511;

    logic [31:0] time_ring  [WINDOW_DEPTH];
    logic [31:0] index_ring [WINDOW_DEPTH];

    logic [8:0]           wf_reg;
    logic [31:0]          thr_reg;
    in_item_t             item_reg;
    logic [AW-1:0]        head_reg;
    logic [CNT_W-1:0]     count_reg;
    logic [SUM_W-1:0]     sum_reg;
    logic                 cap_reg;
    logic [31:0]          last_index_reg;
    logic [47:0]          last_stamp_reg;
    logic [47:0]          last_mem_reg;
    logic [31:0]          last_time_reg;
    logic                 spike_held_reg;
    logic [31:0]          spk_frame_reg;
    logic [31:0]          spk_time_reg;
    logic [2:0]           spk_src_reg;
    logic [31:0]          spk_dom_reg;
    status_t              status_reg;
    logic [CNT_W-1:0]     walk_i_reg;
    logic                 pend_reg;
    logic [31:0]          max_reg;
    logic [SUM_W-1:0]     div_q_reg;
    logic [CNT_W-1:0]     div_r_reg;
    logic [DIV_CNT_W-1:0] div_cnt_reg;
    logic [31:0]          time_rd_reg;
    logic [31:0]          index_rd_reg;
    out_item_t            out_reg;

    logic [8:0]       w_nz;
    logic [CNT_W-1:0] eff;
    logic [31:0]      thr;
    logic             seq_bad;
    logic             record_ok;
    status_t          status_next;
    logic [2:0]       dom_next;
    logic [31:0]      dom_time_next;
    logic [31:0]      sub_time [5];
    logic [AW-1:0]    time_addr;
    logic [AW-1:0]    slot;
    logic [AW-1:0]    head_inc;
    logic [CNT_W:0]   div_trial;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] base,
                                               input logic [CNT_W-1:0] off);
        logic [SW-1:0] s;
        s = SW'(base) + SW'(off);
        if (s >= SW'(WINDOW_DEPTH))
        begin
            s = s - SW'(WINDOW_DEPTH);
        end
        return s[AW-1:0];
    endfunction

    // A length of zero acts as one; anything past the ring depth saturates.
    assign w_nz = (wf_reg == 9'd0) ? 9'd1 : wf_reg;
    assign eff  = (w_nz > CNT_W'(CAP)) ? CNT_W'(CAP) : w_nz;
    assign thr  = (thr_reg == 32'd0) ? 32'd1 : thr_reg;

    assign seq_bad   = (count_reg != '0) &&
                       ((item_reg.frame_number <= last_index_reg) ||
                        (item_reg.stamp_us < last_stamp_reg));
    assign record_ok = (item_reg.opcode == OP_RECORD) && cap_reg &&
                       (item_reg.frame_time != 32'd0) && !seq_bad;

    always_comb
    begin
        status_next = ST_CLEARED;
        unique case (opcode_t'(item_reg.opcode))
            OP_RECORD:
            begin
                if (!cap_reg)
                    status_next = ST_NOT_ACTIVE;
                else if (!record_ok)
                    status_next = ST_INVALID;
                else
                    status_next = ST_RECORDED;
            end
            OP_START: status_next = cap_reg ? ST_ALREADY_ACTIVE : ST_STARTED;
            OP_STOP:  status_next = cap_reg ? ST_STOPPED : ST_NOT_ACTIVE;
            OP_CLEAR: status_next = ST_CLEARED;
            default:  status_next = ST_CLEARED;
        endcase
    end

    assign sub_time[0] = item_reg.render_time;
    assign sub_time[1] = item_reg.script_time;
    assign sub_time[2] = item_reg.asset_time;
    assign sub_time[3] = item_reg.audio_time;
    assign sub_time[4] = item_reg.misc_time;

    // Largest present subsystem; scanning upward with a strict compare keeps
    // the lower number on a tie.
    always_comb
    begin
        dom_next      = NO_SOURCE;
        dom_time_next = 32'd0;
        for (int s = 0; s < 5; s++)
        begin
            if (item_reg.present_mask[s] &&
                ((dom_next == NO_SOURCE) || (sub_time[s] > dom_time_next)))
            begin
                dom_next      = 3'(s);
                dom_time_next = sub_time[s];
            end
        end
    end

    assign time_addr = ring_add(head_reg, walk_i_reg);
    assign slot      = ring_add(head_reg, count_reg);
    assign head_inc  = (head_reg == AW'(WINDOW_DEPTH - 1)) ? '0 : head_reg + 1'b1;
    assign div_trial = {div_r_reg, div_q_reg[SUM_W-1]};

    assign stat.record_ok   = record_ok;
    assign stat.drop_needed = (count_reg >= eff);
    assign stat.walk_done   = (walk_i_reg == count_reg) && !pend_reg;
    assign stat.div_done    = (div_cnt_reg == DIV_CNT_W'(SUM_W));
    assign out_item         = out_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.write)
        begin
            time_ring[slot]  <= item_reg.frame_time;
            index_ring[slot] <= item_reg.frame_number;
        end
        time_rd_reg  <= time_ring[time_addr];
        index_rd_reg <= index_ring[head_reg];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= in_item;
        end
        if (cmd.div_start)
        begin
            div_q_reg   <= sum_reg;
            div_r_reg   <= '0;
            div_cnt_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (div_trial >= {1'b0, count_reg})
            begin
                div_r_reg <= CNT_W'(div_trial - {1'b0, count_reg});
                div_q_reg <= {div_q_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                div_r_reg <= div_trial[CNT_W-1:0];
                div_q_reg <= {div_q_reg[SUM_W-2:0], 1'b0};
            end
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
        if (cmd.publish)
        begin
            out_reg.status          <= status_reg;
            out_reg.active          <= cap_reg;
            out_reg.frames_held     <= count_reg;
            out_reg.latest_time     <= (count_reg != '0) ? last_time_reg : 32'd0;
            out_reg.latest_memory   <= (count_reg != '0) ? last_mem_reg : 48'd0;
            out_reg.average_time    <= (count_reg != '0) ? div_q_reg[31:0] : 32'd0;
            out_reg.maximum_time    <= max_reg;
            out_reg.spike_valid     <= spike_held_reg;
            out_reg.spike_frame     <= spk_frame_reg;
            out_reg.spike_time      <= spk_time_reg;
            out_reg.dominant_source <= spk_src_reg;
            out_reg.dominant_us     <= spk_dom_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wf_reg         <= WINDOW_FRAMES_RST;
            thr_reg        <= SPIKE_THRESHOLD_RST;
            head_reg       <= '0;
            count_reg      <= '0;
            sum_reg        <= '0;
            cap_reg        <= 1'b0;
            last_index_reg <= '0;
            last_stamp_reg <= '0;
            last_mem_reg   <= '0;
            last_time_reg  <= '0;
            spike_held_reg <= 1'b0;
            spk_frame_reg  <= '0;
            spk_time_reg   <= '0;
            spk_src_reg    <= '0;
            spk_dom_reg    <= '0;
            status_reg     <= ST_CLEARED;
            walk_i_reg     <= '0;
            pend_reg       <= 1'b0;
            max_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_WINDOW_FRAMES:   wf_reg <= cfg_data[8:0];
                    REG_SPIKE_THRESHOLD: thr_reg <= cfg_data[31:0];
                    default:             thr_reg <= thr_reg;
                endcase
            end

            if (cmd.load)
            begin
                walk_i_reg <= '0;
                pend_reg   <= 1'b0;
                max_reg    <= '0;
            end

            if (cmd.decide)
            begin
                status_reg <= status_next;
                if (record_ok && (item_reg.frame_time >= thr))
                begin
                    spike_held_reg <= 1'b1;
                    spk_frame_reg  <= item_reg.frame_number;
                    spk_time_reg   <= item_reg.frame_time;
                    spk_src_reg    <= dom_next;
                    spk_dom_reg    <= dom_time_next;
                end
                if ((item_reg.opcode == OP_CLEAR) ||
                    ((item_reg.opcode == OP_START) && !cap_reg))
                begin
                    head_reg       <= '0;
                    count_reg      <= '0;
                    sum_reg        <= '0;
                    last_index_reg <= '0;
                    last_stamp_reg <= '0;
                    last_mem_reg   <= '0;
                    spike_held_reg <= 1'b0;
                    spk_frame_reg  <= '0;
                    spk_time_reg   <= '0;
                    spk_src_reg    <= '0;
                    spk_dom_reg    <= '0;
                end
                if (item_reg.opcode == OP_START)
                begin
                    cap_reg <= 1'b1;
                end
                else if (item_reg.opcode != OP_RECORD)
                begin
                    cap_reg <= 1'b0;
                end
            end

            if (cmd.drop)
            begin
                sum_reg   <= sum_reg - SUM_W'(time_rd_reg);
                head_reg  <= head_inc;
                count_reg <= count_reg - 1'b1;
            end

            if (cmd.write)
            begin
                count_reg      <= count_reg + 1'b1;
                sum_reg        <= sum_reg + SUM_W'(item_reg.frame_time);
                last_index_reg <= item_reg.frame_number;
                last_stamp_reg <= item_reg.stamp_us;
                last_mem_reg   <= item_reg.memory_used;
                last_time_reg  <= item_reg.frame_time;
            end

            // The spike is gone once the oldest held frame is past it.
            if (cmd.check && spike_held_reg && (spk_frame_reg < index_rd_reg))
            begin
                spike_held_reg <= 1'b0;
                spk_frame_reg  <= '0;
                spk_time_reg   <= '0;
                spk_src_reg    <= '0;
                spk_dom_reg    <= '0;
            end

            // Reads are issued one per cycle; each read's data arrives registered in the next cycle.
            if (cmd.walk)
            begin
                if (walk_i_reg < count_reg)
                begin
                    walk_i_reg <= walk_i_reg + 1'b1;
                    pend_reg   <= 1'b1;
                end
                else
                begin
                    pend_reg <= 1'b0;
                end
                if (pend_reg && (time_rd_reg > max_reg))
                begin
                    max_reg <= time_rd_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/frame_time_window_monitor.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel   Direction  Handshake         Payload
// in_ch     in         valid / ready     in_item_t: one command item
// out_ch    out        valid / ready     out_item_t: one result per item
// cfg       in         cfg_we only       cfg_index, cfg_data
//
// A record first drops the oldest held frames as needed to make room, then
// writes the new frame; every command then walks the window and divides. The
// window maximum is a walk over the ring memory, one read a cycle, and the
// average a 41-step divider. The input is ready again in the same cycle that
// the result becomes valid.
// Reset leaves the window empty, capture stopped and registers at defaults.
// A new item is taken while the previous result still waits in the output
// register; the result stage stalls until that register is free.

module frame_time_window_monitor #(
    parameter int unsigned WINDOW_DEPTH = 256
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [ftwm_pkg::CFG_W-1:0] cfg_data,
    ftwm_in_if.sink                    in_ch,
    ftwm_out_if.source                 out_ch
);
    import ftwm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    ftwm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ftwm_datapath #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_item   (in_ch.item),
        .cmd       (cmd),
        .stat      (stat),
        .out_item  (out_ch.item)
    );

endmodule

`default_nettype wire

// ===== rtl/core/ftwm_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ftwm_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_ready,
    input ftwm_pkg::out_item_t out_item
);
    import ftwm_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_item))
        else $error("result changed while stalled");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.frames_held == 9'd0) |->
            (out_item.latest_time == 32'd0) && (out_item.average_time == 32'd0) &&
            (out_item.maximum_time == 32'd0) && !out_item.spike_valid)
        else $error("empty window reports data");

    a_avg_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_item.average_time <= out_item.maximum_time)
        else $error("average above maximum");

    a_recorded: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_RECORDED) |->
            out_item.active && (out_item.frames_held != 9'd0))
        else $error("recorded item without a held frame");

    a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_item.status == ST_CLEARED) |->
            !out_item.active && (out_item.frames_held == 9'd0))
        else $error("clear left state behind");

endmodule

bind frame_time_window_monitor ftwm_checker u_ftwm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_item  (out_ch.item)
);

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import ftwm_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we;
    logic        cfg_index;
    logic [31:0] cfg_data;

    ftwm_in_if  in_ch ();
    ftwm_out_if out_ch ();

    frame_time_window_monitor dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    in_item_t  pending[$];
    out_item_t snapshots_due[$];
    int        errors = 0;
    int        items_in = 0;
    int        items_out = 0;
    bit        quiet = 1'b0;

    // Shadow of the monitor: registers, frame window and latest spike.
    bit [8:0]  win_reg = WINDOW_FRAMES_RST;
    bit [31:0] thr_reg = SPIKE_THRESHOLD_RST;
    bit [31:0] ring_time[256];
    bit [31:0] ring_frame[256];
    bit [7:0]  head;
    int        held;
    bit [40:0] sum;
    bit        capturing;
    bit [31:0] last_frame;
    bit [47:0] last_stamp;
    bit [47:0] last_mem;
    bit        spike_on;
    bit [31:0] spike_f;
    bit [31:0] spike_t;
    bit [2:0]  spike_src;
    bit [31:0] spike_dom;

    // Cursor used to build well-formed frame sequences.
    bit [31:0] next_frame;
    bit [47:0] next_stamp;
    bit        seq_on;

    initial begin
        forever #6 clk = ~clk;
    end

    function automatic void enqueue(in_item_t it);
        pending = {pending, it};
    endfunction

    function automatic void empty_window();
        head = '0;
        held = 0;
        sum = '0;
        last_frame = '0;
        last_stamp = '0;
        last_mem = '0;
        spike_on = 1'b0;
        spike_f = '0;
        spike_t = '0;
        spike_src = '0;
        spike_dom = '0;
    endfunction

    function automatic out_item_t window_result(in_item_t it);
        out_item_t r;
        status_t   st;
        bit [31:0] thr;
        int        depth;
        bit [31:0] sub[5];
        bit [2:0]  dom;
        bit [31:0] dtime;
        bit [7:0]  slot;
        bit [31:0] mx;
        thr = (thr_reg == 0) ? 32'd1 : thr_reg;
        depth = (win_reg == 0) ? 1 : ((win_reg > 256) ? 256 : int'(win_reg));
        sub = '{it.render_time, it.script_time, it.asset_time, it.audio_time, it.misc_time};
        case (opcode_t'(it.opcode))
            OP_RECORD:
            begin
                if (!capturing)
                    st = ST_NOT_ACTIVE;
                else if (it.frame_time == 0)
                    st = ST_INVALID;
                else if (held > 0 && (it.frame_number <= last_frame
                                      || it.stamp_us < last_stamp))
                    st = ST_INVALID;
                else
                begin
                    st = ST_RECORDED;
                    if (it.frame_time >= thr)
                    begin
                        dom = NO_SOURCE;
                        dtime = '0;
                        for (int s = 0; s < 5; s++)
                        begin
                            if (it.present_mask[s]
                                && (sub[s] > dtime || (sub[s] == dtime && s < dom)))
                            begin
                                dom = 3'(s);
                                dtime = sub[s];
                            end
                        end
                        spike_on = 1'b1;
                        spike_f = it.frame_number;
                        spike_t = it.frame_time;
                        spike_src = dom;
                        spike_dom = dtime;
                    end
                    // A lowered window length drops several old frames at once.
                    while (held >= depth)
                    begin
                        sum -= ring_time[head];
                        head++;
                        held--;
                    end
                    slot = head + 8'(held);
                    ring_time[slot] = it.frame_time;
                    ring_frame[slot] = it.frame_number;
                    held++;
                    sum += it.frame_time;
                    last_frame = it.frame_number;
                    last_stamp = it.stamp_us;
                    last_mem = it.memory_used;
                    if (spike_on && spike_f < ring_frame[head])
                    begin
                        spike_on = 1'b0;
                        spike_f = '0;
                        spike_t = '0;
                        spike_src = '0;
                        spike_dom = '0;
                    end
                end
            end
            OP_START:
            begin
                if (capturing)
                    st = ST_ALREADY_ACTIVE;
                else
                begin
                    empty_window();
                    capturing = 1'b1;
                    st = ST_STARTED;
                end
            end
            OP_STOP:
            begin
                st = capturing ? ST_STOPPED : ST_NOT_ACTIVE;
                capturing = 1'b0;
            end
            default:
            begin
                capturing = 1'b0;
                empty_window();
                st = ST_CLEARED;
            end
        endcase
        mx = '0;
        for (int i = 0; i < held; i++)
            if (ring_time[8'(head + 8'(i))] > mx)
                mx = ring_time[8'(head + 8'(i))];
        r = '0;
        r.status = st;
        r.active = capturing;
        r.frames_held = 9'(held);
        if (held > 0)
        begin
            r.latest_time = ring_time[8'(head + 8'(held - 1))];
            r.latest_memory = last_mem;
            r.average_time = 32'(sum / held);
            r.maximum_time = mx;
        end
        if (spike_on)
        begin
            r.spike_valid = 1'b1;
            r.spike_frame = spike_f;
            r.spike_time = spike_t;
            r.dominant_source = spike_src;
            r.dominant_us = spike_dom;
        end
        return r;
    endfunction

    function automatic bit [31:0] pick_sub();
        case ($urandom_range(0, 3))
            0: return 32'd0;
            1: return 32'd777;
            2: return $urandom_range(0, 3000);
            default: return $urandom;
        endcase
    endfunction

    function automatic in_item_t frame_item(opcode_t op, bit [31:0] f, bit [47:0] st,
                                            bit [31:0] t, bit [4:0] mask);
        in_item_t it;
        it.opcode = op;
        it.frame_number = f;
        it.stamp_us = st;
        it.frame_time = t;
        it.memory_used = 48'({$urandom, $urandom});
        it.present_mask = mask;
        it.render_time = pick_sub();
        it.script_time = pick_sub();
        it.asset_time = pick_sub();
        it.audio_time = pick_sub();
        it.misc_time = pick_sub();
        return it;
    endfunction

    function automatic bit [31:0] pick_time(bit [31:0] tmax);
        case ($urandom_range(0, 19))
            0: return $urandom | 32'd1;
            1: return 32'hFFFF_FFFF;
            default: return $urandom_range(1, tmax);
        endcase
    endfunction

    // Mostly well-formed capture sessions, with some commands out of order
    // and some malformed frames.
    task automatic queue_session(int n, bit [31:0] tmax);
        int        r;
        in_item_t  it;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if ((!seq_on && r < 40) || r < 2)
            begin
                it = frame_item(OP_START, $urandom, 48'({$urandom, $urandom}), $urandom,
                                5'($urandom));
                seq_on = 1'b1;
                next_frame = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 1000);
                next_stamp = ($urandom_range(0, 7) == 0) ? 48'({$urandom, $urandom})
                                                         : 48'($urandom_range(0, 5000));
            end
            else if (r < 4)
            begin
                it = frame_item(OP_STOP, $urandom, 48'({$urandom, $urandom}), $urandom,
                                5'($urandom));
                seq_on = 1'b0;
            end
            else if (r < 6)
            begin
                it = frame_item(OP_CLEAR, $urandom, 48'({$urandom, $urandom}), $urandom,
                                5'($urandom));
                seq_on = 1'b0;
            end
            else if (r < 12)
            begin
                case ($urandom_range(0, 2))
                    0: it = frame_item(OP_RECORD, next_frame, next_stamp, pick_time(tmax),
                                       5'($urandom));
                    1: it = frame_item(OP_RECORD, next_frame + 1, next_stamp - 1,
                                       pick_time(tmax), 5'($urandom));
                    default: it = frame_item(OP_RECORD, next_frame + 1, next_stamp, 32'd0,
                                             5'($urandom));
                endcase
            end
            else
            begin
                next_frame += $urandom_range(1, 3);
                next_stamp += $urandom_range(0, 20000);
                it = frame_item(OP_RECORD, next_frame, next_stamp, pick_time(tmax),
                                5'($urandom));
            end
            enqueue(it);
        end
    endtask

    task automatic write_reg(logic idx, logic [31:0] value);
        wait (pending.size() == 0 && snapshots_due.size() == 0 && in_ch.valid == 1'b0);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        if (idx == REG_WINDOW_FRAMES)
            win_reg = value[8:0];
        else
            thr_reg = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got)
        begin
            errors++;
            $display("%0t ns: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    // Sender: bursts of idle cycles, none in the final phase.
    int send_gap = 0;
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                snapshots_due = {snapshots_due, window_result(in_ch.item)};
                items_in++;
                if (!quiet && (items_in % 300) < 200 && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 17);
            end
            if (in_ch.valid && !in_ch.ready)
                in_ch.valid <= 1'b1;
            else if (send_gap > 0)
            begin
                send_gap--;
                in_ch.valid <= 1'b0;
            end
            else if (pending.size() > 0)
            begin
                in_ch.valid <= 1'b1;
                in_ch.item <= pending.pop_front();
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Receiver: random stalls plus one long hold-off that backs up the input.
    int  stall = 0;
    int  hold_left = 0;
    bit  held_once = 1'b0;
    always @(posedge clk)
    begin
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got = out_ch.item;
                items_out++;
                if (snapshots_due.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with none expected, actual %0h", $time, got);
                end
                else
                begin
                    want = snapshots_due.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("active", 64'(want.active), 64'(got.active));
                    check_field("frames_held", 64'(want.frames_held), 64'(got.frames_held));
                    check_field("latest_time", 64'(want.latest_time), 64'(got.latest_time));
                    check_field("latest_memory", 64'(want.latest_memory),
                                64'(got.latest_memory));
                    check_field("average_time", 64'(want.average_time),
                                64'(got.average_time));
                    check_field("maximum_time", 64'(want.maximum_time),
                                64'(got.maximum_time));
                    check_field("spike_valid", 64'(want.spike_valid), 64'(got.spike_valid));
                    check_field("spike_frame", 64'(want.spike_frame), 64'(got.spike_frame));
                    check_field("spike_time", 64'(want.spike_time), 64'(got.spike_time));
                    check_field("dominant_source", 64'(want.dominant_source),
                                64'(got.dominant_source));
                    check_field("dominant_us", 64'(want.dominant_us), 64'(got.dominant_us));
                end
                if (items_out == 250 && !held_once)
                begin
                    held_once = 1'b1;
                    hold_left = 3000;
                end
                else if (!quiet && (items_out % 250) > 80 && $urandom_range(0, 4) == 0)
                    stall = $urandom_range(1, 17);
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end
            else if (stall > 0)
            begin
                stall--;
                out_ch.ready <= 1'b0;
            end
            else
                out_ch.ready <= 1'b1;
        end
    end

    int cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 5000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cfg_we = 1'b0;
        cfg_index = REG_WINDOW_FRAMES;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.item = '0;
        out_ch.ready = 1'b0;
        seq_on = 1'b0;
        capturing = 1'b0;
        empty_window();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Command order, rejection rules, spike ties and field extremes.
        enqueue(frame_item(OP_RECORD, 32'd1, 48'd1, 32'd5, 5'd0));
        enqueue(frame_item(OP_STOP, 32'd0, 48'd0, 32'd0, 5'd0));
        enqueue(frame_item(OP_START, 32'd0, 48'd0, 32'd0, 5'd0));
        enqueue(frame_item(OP_START, 32'd0, 48'd0, 32'd0, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'd0, 48'd0, 32'd0, 5'd31));
        enqueue(frame_item(OP_RECORD, 32'd0, 48'd0, 32'd1, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'd0, 48'd5, 32'd9, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'd5, 48'd100, 32'd16667, 5'd31));
        pending[$].render_time = 32'd900;
        pending[$].script_time = 32'd900;
        pending[$].asset_time = 32'd12;
        enqueue(frame_item(OP_RECORD, 32'd6, 48'd99, 32'd20000, 5'd31));
        enqueue(frame_item(OP_RECORD, 32'd7, 48'd100, 32'hFFFF_FFFF, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'd8, 48'hFFFF_FFFF_FFFF, 32'd16666, 5'b10000));
        pending[$].memory_used = 48'hFFFF_FFFF_FFFF;
        enqueue(frame_item(OP_RECORD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd1, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 32'd3, 5'd0));
        enqueue(frame_item(OP_STOP, 32'd0, 48'd0, 32'd0, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'd1, 48'd1, 32'd5, 5'd0));
        enqueue(frame_item(OP_CLEAR, 32'd0, 48'd0, 32'd0, 5'd0));
        enqueue(frame_item(OP_START, 32'd0, 48'd0, 32'd0, 5'd0));
        enqueue(frame_item(OP_RECORD, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF,
                           32'hFFFF_FFFF, 5'd31));
        pending[$].render_time = 32'hFFFF_FFFF;
        pending[$].script_time = 32'hFFFF_FFFF;
        pending[$].asset_time = 32'hFFFF_FFFF;
        pending[$].audio_time = 32'hFFFF_FFFF;
        pending[$].misc_time = 32'hFFFF_FFFF;
        enqueue(frame_item(OP_CLEAR, 32'd0, 48'd0, 32'd0, 5'd0));

        queue_session(150, 20000);
        write_reg(REG_WINDOW_FRAMES, 32'd0);
        write_reg(REG_SPIKE_THRESHOLD, 32'd0);
        queue_session(200, 4);
        write_reg(REG_WINDOW_FRAMES, 32'd511);
        write_reg(REG_SPIKE_THRESHOLD, 32'hFFFF_FFFF);
        queue_session(120, 40000);
        // Shrinking the window here drops many held frames on the next record.
        write_reg(REG_WINDOW_FRAMES, 32'd8);
        write_reg(REG_SPIKE_THRESHOLD, 32'd5000);
        queue_session(400, 8000);
        write_reg(REG_WINDOW_FRAMES, 32'd3);
        write_reg(REG_SPIKE_THRESHOLD, 32'd1);
        queue_session(100, 30);
        write_reg(REG_WINDOW_FRAMES, 32'd16);
        write_reg(REG_SPIKE_THRESHOLD, 32'd12000);
        quiet = 1'b1;
        queue_session(250, 15000);

        wait (pending.size() == 0 && snapshots_due.size() == 0 && in_ch.valid == 1'b0);
        repeat (1000) @(posedge clk);
        if (errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
